### src/phn_pkg.sv
package phn_pkg;

	localparam int SUM_W = 18;
	localparam int COUNT_W = 8;
	localparam logic [SUM_W-1:0] SUM_MAX = 18'h3FFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

endpackage

### src/phn_div.sv
module phn_div #(
	parameter int DW = 24,
	parameter int VW = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [$clog2(DW+1)-1:0]     steps,
	input  logic [DW-1:0]               dividend,
	input  logic [VW-1:0]               divisor,
	output logic                        done,
	output logic [DW-1:0]               quotient,
	output logic [VW-1:0]               remainder
);
	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [VW:0]   r_shift;
	logic [VW+1:0] diff;
	logic          fits;

	// one quotient bit per cycle, restoring
	assign r_shift = {rem_q, dvd_q[DW-1]};
	assign diff = {1'b0, r_shift} - {2'b00, dsr_q};
	assign fits = ~diff[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : r_shift[VW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
	assign remainder = rem_q;

endmodule

### src/perfect_harmonic_number_test.sv
// perfect and harmonic divisor number test
//
// command channel: drive number and pulse start while busy is low; the
// transfer happens at that clock edge. busy stays high until the result
// is out. done is high for a single cycle and marks the result on the
// output ports; the receiver cannot stall it and must take it then.
//
// divisors are found by trial division of number by i = 1, 2, ... up to
// floor(sqrt(number)), on one shared bit-serial restoring divider that
// produces one quotient bit per cycle. each trial passes through S_TRY
// and S_WAIT, and through S_ADDQ as well when a divisor pair is found.
// the harmonic test then multiplies count by number, one count bit per
// cycle, and reduces the product modulo the divisor sum on the same
// divider. a zero number gives input_rejected on the cycle after the
// transfer. one item is in work at a time; the next transfer can happen
// in the cycle that carries done. reset returns the block to idle; no
// result is pending after reset.
module perfect_harmonic_number_test #(
	parameter int NUMBER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [NUMBER_WIDTH-1:0]        number,
	output logic                           done,
	output logic [phn_pkg::SUM_W-1:0]      proper_divisor_sum,
	output logic [phn_pkg::COUNT_W-1:0]    divisor_count,
	output logic                           is_perfect,
	output logic                           is_harmonic,
	output logic                           input_rejected
);
	import phn_pkg::*;

	localparam int W = NUMBER_WIDTH;
	localparam int CW = (W + 1) / 2 + 2;
	localparam int SW = W + 4;
	localparam int PW = W + CW;
	localparam int KW = $clog2(PW + 1);
	localparam int MW = $clog2(CW + 1);
	localparam int SXW = (SW > SUM_W) ? SW : SUM_W;
	localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TRY = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_ADDQ = 3'd3;
	localparam logic [2:0] S_MUL = 3'd4;
	localparam logic [2:0] S_MOD = 3'd5;
	localparam logic [2:0] S_MWAIT = 3'd6;

	logic [2:0]    state_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  i_q;
	logic [W-1:0]  quo_q;
	logic [SW-1:0] sigma_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cshift_q;
	logic [MW-1:0] mcnt_q;
	logic [PW-1:0] prod_q;

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] cnt_out_q;
	logic               perf_q;
	logic               harm_q;
	logic               rej_q;
	logic               done_q;

	logic          div_start;
	logic [KW-1:0] div_steps;
	logic [PW-1:0] div_dividend;
	logic [SW-1:0] div_divisor;
	logic          div_done;
	logic [PW-1:0] div_quot;
	logic [SW-1:0] div_rem;

	logic [W-1:0]   trial;
	logic [SW-1:0]  proper;
	logic [SXW-1:0] proper_x;
	logic [CXW-1:0] count_x;

	phn_div #(
		.DW(PW),
		.VW(SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.steps     (div_steps),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_comb begin
		div_start = 1'b0;
		div_steps = KW'(W);
		div_dividend = {n_q, {CW{1'b0}}};
		div_divisor = SW'(i_q);
		case (state_q)
			S_TRY: begin
				div_start = 1'b1;
			end
			S_MOD: begin
				div_start = 1'b1;
				div_steps = KW'(PW);
				div_dividend = prod_q;
				div_divisor = sigma_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign trial = div_quot[W-1:0];
	assign proper = sigma_q - SW'(n_q);
	assign proper_x = SXW'(proper);
	assign count_x = CXW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (number == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_TRY;
						end
					end
				end
				S_TRY: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						if (trial < i_q) begin
							state_q <= S_MUL;
						end else if (div_rem == '0 && trial != i_q) begin
							state_q <= S_ADDQ;
						end else begin
							state_q <= S_TRY;
						end
					end
				end
				S_ADDQ: begin
					state_q <= S_TRY;
				end
				S_MUL: begin
					if (mcnt_q == MW'(1)) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (div_done) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					n_q <= number;
					i_q <= W'(1);
					sigma_q <= '0;
					count_q <= '0;
					if (number == '0) begin
						sum_q <= '0;
						cnt_out_q <= '0;
						perf_q <= 1'b0;
						harm_q <= 1'b0;
						rej_q <= 1'b1;
					end
				end
			end
			S_WAIT: begin
				if (div_done) begin
					quo_q <= trial;
					if (trial < i_q) begin
						cshift_q <= count_q;
						mcnt_q <= MW'(CW);
						prod_q <= '0;
					end else begin
						if (div_rem == '0) begin
							sigma_q <= sigma_q + SW'(i_q);
							count_q <= count_q + CW'(1);
						end
						if (div_rem != '0 || trial == i_q) begin
							i_q <= i_q + W'(1);
						end
					end
				end
			end
			S_ADDQ: begin
				sigma_q <= sigma_q + SW'(quo_q);
				count_q <= count_q + CW'(1);
				i_q <= i_q + W'(1);
			end
			S_MUL: begin
				// shift-add, count msb first
				prod_q <= {prod_q[PW-2:0], 1'b0} + (cshift_q[CW-1] ? PW'(n_q) : PW'(0));
				cshift_q <= {cshift_q[CW-2:0], 1'b0};
				mcnt_q <= mcnt_q - MW'(1);
			end
			S_MWAIT: begin
				if (div_done) begin
					sum_q <= (proper_x > SXW'(SUM_MAX)) ? SUM_MAX : proper_x[SUM_W-1:0];
					cnt_out_q <= (count_x > CXW'(COUNT_MAX)) ? COUNT_MAX
						: count_x[COUNT_W-1:0];
					perf_q <= (proper == SW'(n_q));
					harm_q <= (div_rem == '0);
					rej_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign proper_divisor_sum = sum_q;
	assign divisor_count = cnt_out_q;
	assign is_perfect = perf_q;
	assign is_harmonic = harm_q;
	assign input_rejected = rej_q;

endmodule
